### design/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared types and constants for the 4x4 fixed-point matrix-vector transform.
// ----------------------------------------------------------------------------
package mvt_pkg;

    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;
    localparam int LANES     = 4;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 2;

    // Full product, product after the fraction shift, and the exact row sum.
    localparam int PROD_W = 2 * DATA_W;
    localparam int SHR_W  = PROD_W - FRAC_BITS;
    localparam int SUM_W  = SHR_W + $clog2(LANES);

    // Stream payload layout.
    localparam int IN_BITS     = 2 * IDX_W + DATA_W * (1 + LANES);
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = DATA_W * LANES;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_XFORM = 1'b1
    } t_opcode;

    typedef struct packed {
        t_word value;
        logic  sat;
    } t_row_result;

    localparam t_word FIX_ONE = t_word'(longint'(1) << FRAC_BITS);
    localparam t_sum  SUM_MAX = t_sum'((longint'(1) << (DATA_W - 1)) - 1);
    localparam t_sum  SUM_MIN = t_sum'(-(longint'(1) << (DATA_W - 1)));
    localparam t_word WORD_MAX = t_word'((longint'(1) << (DATA_W - 1)) - 1);
    localparam t_word WORD_MIN = t_word'(-(longint'(1) << (DATA_W - 1)));

endpackage

### design/mvt_row_sum.sv
// ----------------------------------------------------------------------------
// mvt_row_sum
// Shifts the products of one matrix row, sums them exactly and saturates.
// ----------------------------------------------------------------------------
module mvt_row_sum (
    input  mvt_pkg::t_prod       i_prod [mvt_pkg::LANES],
    output mvt_pkg::t_row_result o_result
);

    mvt_pkg::t_sum w_sum;

    // Arithmetic shift rounds toward minus infinity; the shifted value fits
    // the sum width, so the size cast only drops copies of the sign bit.
    always_comb begin
        w_sum = '0;
        for (int k = 0; k < mvt_pkg::LANES; k++) begin
            w_sum = w_sum + mvt_pkg::t_sum'(i_prod[k] >>> mvt_pkg::FRAC_BITS);
        end
    end

    always_comb begin
        if (w_sum > mvt_pkg::SUM_MAX) begin
            o_result.value = mvt_pkg::WORD_MAX;
            o_result.sat   = 1'b1;
        end else if (w_sum < mvt_pkg::SUM_MIN) begin
            o_result.value = mvt_pkg::WORD_MIN;
            o_result.sat   = 1'b1;
        end else begin
            o_result.value = mvt_pkg::t_word'(w_sum);
            o_result.sat   = 1'b0;
        end
    end

endmodule

### design/matrix4_vector_transform_top.sv
// ----------------------------------------------------------------------------
// matrix4_vector_transform_top
// 4x4 Q16.16 matrix-vector transform with per-entry matrix load.
// ----------------------------------------------------------------------------
// Pipeline: a transform result reaches the master side through the input
// register, the product register and the result register. Throughput: one
// transaction per cycle, loads and transforms alike, while the master side
// takes results; when it holds them back, the pipe stalls.
// Reset (synchronous, active low) empties the pipeline and sets the identity.
// ----------------------------------------------------------------------------
module matrix4_vector_transform_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0 up: row_index[1:0], col_index[3:2], entry_value[35:4],
    // in_x[67:36], in_y[99:68], in_z[131:100], in_w[163:132], zero padding.
    input  logic [mvt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Fields: opcode[0].
    input  logic                               s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields from bit 0 up: out_x[31:0], out_y[63:32], out_z[95:64],
    // out_w[127:96].
    output logic [mvt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // Fields: overflow[0].
    output logic                               m_axis_tuser
);

    localparam int ROW_LSB = 0;
    localparam int COL_LSB = ROW_LSB + mvt_pkg::IDX_W;
    localparam int VAL_LSB = COL_LSB + mvt_pkg::IDX_W;
    localparam int VEC_LSB = VAL_LSB + mvt_pkg::DATA_W;

    // ------------------------------------------------------------------
    // Input register. Every accepted transaction lands here first; a load
    // updates the matrix only when it leaves this register, so it is ordered
    // against transforms ahead of it, which read the matrix as they leave.
    // ------------------------------------------------------------------
    logic                      r_in_valid;
    mvt_pkg::t_opcode          r_in_op;
    logic [mvt_pkg::IDX_W-1:0] r_in_row;
    logic [mvt_pkg::IDX_W-1:0] r_in_col;
    mvt_pkg::t_word            r_in_value;
    mvt_pkg::t_word            r_in_vec [mvt_pkg::LANES];

    // Matrix store, row major.
    mvt_pkg::t_word            r_matrix [mvt_pkg::DIM][mvt_pkg::DIM];

    // Product register.
    logic                      r_p_valid;
    mvt_pkg::t_prod            r_prod [mvt_pkg::LANES][mvt_pkg::LANES];
    mvt_pkg::t_prod            w_prod [mvt_pkg::LANES][mvt_pkg::LANES];

    // Result register.
    logic                                  r_out_valid;
    logic [mvt_pkg::OUT_TDATA_W-1:0]       r_out_data;
    logic                                  r_out_ovf;
    logic [mvt_pkg::OUT_TDATA_W-1:0]       n_out_data;
    logic                                  n_out_ovf;
    mvt_pkg::t_row_result                  w_row [mvt_pkg::LANES];

    // Stage advance controls. Each stage moves when the stage after it is
    // empty or moving, so bubbles collapse and the pipe never idles while
    // the master side is taking results.
    logic w_out_adv;
    logic w_p_adv;
    logic w_in_leave;
    logic w_in_take;
    logic w_load_wr;

    always_comb begin
        w_out_adv  = !r_out_valid || m_axis_tready;
        w_p_adv    = !r_p_valid || w_out_adv;
        // A load needs no room downstream; it retires from the input register.
        w_in_leave = r_in_valid && ((r_in_op == mvt_pkg::OP_LOAD) || w_p_adv);
        w_in_take  = !r_in_valid || w_in_leave;
        w_load_wr  = w_in_leave && (r_in_op == mvt_pkg::OP_LOAD);
    end

    assign s_axis_tready = w_in_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take && s_axis_tvalid) begin
            r_in_op    <= mvt_pkg::t_opcode'(s_axis_tuser);
            r_in_row   <= s_axis_tdata[ROW_LSB +: mvt_pkg::IDX_W];
            r_in_col   <= s_axis_tdata[COL_LSB +: mvt_pkg::IDX_W];
            r_in_value <= s_axis_tdata[VAL_LSB +: mvt_pkg::DATA_W];
            for (int k = 0; k < mvt_pkg::LANES; k++) begin
                r_in_vec[k] <= s_axis_tdata[VEC_LSB + k * mvt_pkg::DATA_W +: mvt_pkg::DATA_W];
            end
        end
    end

    // Matrix store: identity after reset. A load whose row or column lies
    // outside the matrix matches no entry and is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < mvt_pkg::DIM; r++) begin
                for (int c = 0; c < mvt_pkg::DIM; c++) begin
                    r_matrix[r][c] <= (r == c) ? mvt_pkg::FIX_ONE : '0;
                end
            end
        end else if (w_load_wr) begin
            for (int r = 0; r < mvt_pkg::DIM; r++) begin
                for (int c = 0; c < mvt_pkg::DIM; c++) begin
                    if ((int'(r_in_row) == r) && (int'(r_in_col) == c)) begin
                        r_matrix[r][c] <= r_in_value;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sixteen independent signed 32x32 multipliers. Rows past the matrix
    // give zero, and matrix columns past the four vector components are
    // never used.
    // ------------------------------------------------------------------
    for (genvar gr = 0; gr < mvt_pkg::LANES; gr++) begin : g_prod_row
        for (genvar gk = 0; gk < mvt_pkg::LANES; gk++) begin : g_prod_col
            if ((gr < mvt_pkg::DIM) && (gk < mvt_pkg::DIM)) begin : g_mul
                assign w_prod[gr][gk] = mvt_pkg::t_prod'(r_in_vec[gk])
                                      * mvt_pkg::t_prod'(r_matrix[gr][gk]);
            end else begin : g_zero
                assign w_prod[gr][gk] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_p_adv) begin
            r_p_valid <= w_in_leave && (r_in_op == mvt_pkg::OP_XFORM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_adv && w_in_leave && (r_in_op == mvt_pkg::OP_XFORM)) begin
            r_prod <= w_prod;
        end
    end

    // ------------------------------------------------------------------
    // Per-row shift, exact sum and saturation, then the result register.
    // ------------------------------------------------------------------
    for (genvar gr = 0; gr < mvt_pkg::LANES; gr++) begin : g_row
        mvt_row_sum u_row_sum (
            .i_prod   (r_prod[gr]),
            .o_result (w_row[gr])
        );
    end

    always_comb begin
        n_out_data = '0;
        n_out_ovf  = 1'b0;
        for (int r = 0; r < mvt_pkg::LANES; r++) begin
            n_out_data[r * mvt_pkg::DATA_W +: mvt_pkg::DATA_W] = w_row[r].value;
            n_out_ovf = n_out_ovf | w_row[r].sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv && r_p_valid) begin
            r_out_data <= n_out_data;
            r_out_ovf  <= n_out_ovf;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_ovf;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A load retiring from the input register never creates a product.
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_leave && (r_in_op == mvt_pkg::OP_LOAD) && w_p_adv) |=> !r_p_valid)
        else $error("load produced a product stage entry");

    // A transform that leaves the input register is held in the product stage.
    a_xform_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_leave && (r_in_op == mvt_pkg::OP_XFORM)) |=> r_p_valid)
        else $error("transform lost between input and product stage");

    // The overflow flag is only raised when some component is at a rail.
    a_ovf_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            ((r_out_data[31:0]   == mvt_pkg::WORD_MAX) ||
             (r_out_data[31:0]   == mvt_pkg::WORD_MIN) ||
             (r_out_data[63:32]  == mvt_pkg::WORD_MAX) ||
             (r_out_data[63:32]  == mvt_pkg::WORD_MIN) ||
             (r_out_data[95:64]  == mvt_pkg::WORD_MAX) ||
             (r_out_data[95:64]  == mvt_pkg::WORD_MIN) ||
             (r_out_data[127:96] == mvt_pkg::WORD_MAX) ||
             (r_out_data[127:96] == mvt_pkg::WORD_MIN)))
        else $error("overflow flagged without a saturated component");

    // Reset restores the identity: entry (0,0) is one and entry (0,1) is zero.
    a_reset_identity: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_matrix[0][0] == mvt_pkg::FIX_ONE) && (r_matrix[0][1] == '0))
        else $error("matrix not at identity after reset");

endmodule
